// ===== hdl/latency_max_avg_monitor_assert.svh =====
// Assertion macros shared by the latency monitor RTL files.
`ifndef LATENCY_MAX_AVG_MONITOR_ASSERT_SVH
`define LATENCY_MAX_AVG_MONITOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is asserted.
`define LMAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property, evaluated at every rising clock edge, reset included.
`define LMAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LMAM_ASSERT(lbl, prop, msg)
`define LMAM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/lmam_pkg.sv =====
// Shared constants, codes and types of the latency monitor.
package lmam_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned AccW   = DurW + CountW;
  localparam int unsigned DvsW   = CountW + 1;
  localparam int unsigned DivSteps = DurW;
  localparam int unsigned StepW  = $clog2(DivSteps);

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_START_OPEN  = 2'd1,
    STAT_FINISH_IDLE = 2'd2
  } status_e;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== hdl/lmam_evt_if.sv =====
// Handshake channel that carries start and finish events into the monitor.
interface lmam_evt_if
  import lmam_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [TimeW-1:0]  now;
  logic [TagW-1:0]   tag;

  modport source (output valid, func, now, tag, input ready);
  modport sink   (input valid, func, now, tag, output ready);
endinterface

// ===== hdl/lmam_res_if.sv =====
// Handshake channel that carries monitor results out of the block.
interface lmam_res_if
  import lmam_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              open;
  logic [DurW-1:0]   max_duration;
  logic [TagW-1:0]   max_tag;
  logic [DurW-1:0]   avg_duration;
  logic [CountW-1:0] sample_count;

  modport source (output valid, status, open, max_duration, max_tag, avg_duration,
                  sample_count, input ready);
  modport sink   (input valid, status, open, max_duration, max_tag, avg_duration,
                  sample_count, output ready);
endinterface

// ===== hdl/lmam_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, quotient known to fit DurW bits.
`include "latency_max_avg_monitor_assert.svh"

module lmam_div
  import lmam_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_ctl_t            ctl_i,
  input  logic [AccW-1:0]     dividend_i,
  input  logic [DvsW-1:0]     divisor_i,
  output div_sts_t            sts_o,
  output logic [DurW-1:0]     quotient_o
);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [DvsW-1:0]  rem_q;
  logic [DurW-1:0]  quo_q;
  logic [DvsW-1:0]  dvs_q;

  logic [DvsW:0]    rem_sh;
  logic             fits;
  logic [DvsW:0]    rem_sub;

  // The remainder stays below the divisor, so the shifted remainder is below twice it.
  assign rem_sh  = {rem_q, quo_q[DurW-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= DvsW'(dividend_i[AccW-1:DurW]);
      quo_q <= dividend_i[DurW-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
      quo_q <= {quo_q[DurW-2:0], fits};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

  `LMAM_ASSERT(a_rem_below_dvs, busy_q |-> (rem_q < dvs_q), "divider remainder not below divisor")
  `LMAM_ASSERT(a_start_busy, ctl_i.start |=> busy_q, "divider did not start")
  `LMAM_ASSERT(a_done_idle, done_q |-> !busy_q, "divider done while still busy")

endmodule

// ===== hdl/latency_max_avg_monitor.sv =====
// Latency monitor: tracks section durations, their maximum and a running average.
// A start or ignored event goes straight to EMIT, then to the output register once free.
// Below saturation, a counted finish takes one multiply, one add, then 32 divider steps.
// The divider yields one quotient bit per cycle; one event is in work at a time.
// Reset (asynchronous, active low) clears all measurement state and the output valid flag.
`include "latency_max_avg_monitor_assert.svh"

module latency_max_avg_monitor
  import lmam_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lmam_evt_if.sink    evt_i,
  lmam_res_if.source  res_o
);

  // The sequencer walks a finish event through multiply, add and divide, then
  // waits in EMIT until the output register is free to take the result.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q;

  // Measurement state.
  logic              running_q;
  logic [TimeW-1:0]  start_time_q;
  logic [TagW-1:0]   start_tag_q;
  logic [DurW-1:0]   longest_q;
  logic [TagW-1:0]   longest_tag_q;
  logic [DurW-1:0]   mean_q;
  logic [CountW-1:0] samples_q;

  // Working registers of the average update.
  logic [DurW-1:0]   dur_q;
  logic [AccW-1:0]   prod_q;
  status_e           status_q;

  // Output register; it holds a result while the next event is already in work.
  logic              res_valid_q;
  status_e           res_status_q;
  logic              res_open_q;
  logic [DurW-1:0]   res_max_q;
  logic [TagW-1:0]   res_max_tag_q;
  logic [DurW-1:0]   res_avg_q;
  logic [CountW-1:0] res_count_q;

  logic              evt_xfer;
  logic              finish_counted;
  logic [DurW-1:0]   dur;
  logic              emit_go;

  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [AccW-1:0]   div_dividend;
  logic [DvsW-1:0]   div_divisor;
  logic [DurW-1:0]   div_quotient;

  assign evt_i.ready    = (state_q == ST_IDLE);
  assign evt_xfer       = evt_i.valid && evt_i.ready;
  assign finish_counted = evt_xfer && (evt_i.func == FUNC_FINISH) && running_q;

  // The duration wraps modulo the timestamp width.
  assign dur = DurW'(evt_i.now - start_time_q);

  // The result may move into the output register when it is empty or being drained.
  assign emit_go = (state_q == ST_EMIT) && (!res_valid_q || res_o.ready);

  // The sum mean*samples + d goes straight into the divider's working registers.
  assign div_ctl.start = (state_q == ST_ADD);
  assign div_dividend  = prod_q + AccW'(dur_q);
  assign div_divisor   = DvsW'(samples_q) + 1'b1;

  lmam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      running_q     <= 1'b0;
      start_time_q  <= '0;
      start_tag_q   <= '0;
      longest_q     <= '0;
      longest_tag_q <= '0;
      mean_q        <= '0;
      samples_q     <= '0;
      status_q      <= STAT_OK;
      res_valid_q   <= 1'b0;
    end else begin
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (evt_xfer) begin
            state_q  <= ST_EMIT;
            status_q <= STAT_OK;
            if (evt_i.func == FUNC_START) begin
              if (running_q) begin
                status_q <= STAT_START_OPEN;
              end else begin
                start_time_q <= evt_i.now;
                start_tag_q  <= evt_i.tag;
                running_q    <= 1'b1;
              end
            end else if (!running_q) begin
              status_q <= STAT_FINISH_IDLE;
            end else begin
              running_q <= 1'b0;
              dur_q     <= dur;
              // A tie with the stored maximum keeps the older tag.
              if (dur > longest_q) begin
                longest_q     <= dur;
                longest_tag_q <= start_tag_q;
              end
              // Once the count is saturated the average is frozen.
              if (samples_q != '1) begin
                state_q <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          prod_q  <= AccW'(mean_q) * AccW'(samples_q);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_sts.done) begin
            mean_q    <= div_quotient;
            samples_q <= samples_q + 1'b1;
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload; its qualifier is res_valid_q.
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      res_status_q  <= status_q;
      res_open_q    <= running_q;
      res_max_q     <= longest_q;
      res_max_tag_q <= longest_tag_q;
      res_avg_q     <= mean_q;
      res_count_q   <= samples_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_status_q;
  assign res_o.open         = res_open_q;
  assign res_o.max_duration = res_max_q;
  assign res_o.max_tag      = res_max_tag_q;
  assign res_o.avg_duration = res_avg_q;
  assign res_o.sample_count = res_count_q;

  // The truncated average of durations can never exceed the largest of them.
  `LMAM_ASSERT(a_avg_le_max, mean_q <= longest_q, "average exceeds maximum duration")
  // The sample count only ever grows.
  `LMAM_ASSERT(a_count_mono, samples_q >= $past(samples_q), "sample count decreased")
  // A finish transfer while a measurement is open always closes it.
  `LMAM_ASSERT(a_finish_closes, finish_counted |=> !running_q, "finish left measurement open")

endmodule

// ===== dv/latency_max_avg_monitor_tb.sv =====
// Self-checking testbench for the latency monitor with random event traffic and stalls.
`timescale 1ns / 1ps

module latency_max_avg_monitor_tb
  import lmam_pkg::*;
;

  // One pending event for the sender. A drain item is held back until every
  // earlier event has produced its result.
  typedef struct {
    logic             func;
    bit [TimeW-1:0]   stamp;
    bit [TagW-1:0]    tag;
    bit               drain;
  } section_event_t;

  // The monitor snapshot that one event is expected to produce.
  typedef struct {
    status_e          status;
    bit               open;
    bit [DurW-1:0]    max_duration;
    bit [TagW-1:0]    max_tag;
    bit [DurW-1:0]    avg_duration;
    bit [CountW-1:0]  sample_count;
  } monitor_snapshot_t;

  localparam int unsigned RandomEvents = 700;
  localparam int unsigned SettleCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  lmam_evt_if evt ();
  lmam_res_if res ();

  latency_max_avg_monitor DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .res_o  (res)
  );

  always #2 clk_i = ~clk_i;

  // Events still to be sent; the head is the one on the bus while valid is high.
  section_event_t    event_backlog[$];
  // Snapshots predicted for accepted events, oldest first.
  monitor_snapshot_t due_snapshots[$];

  int unsigned mismatch_count = 0;
  // Events accepted whose result has not yet been transferred out.
  int unsigned in_flight = 0;

  // Shadow copy of the monitor state, updated once per accepted event.
  bit              sect_open  = 1'b0;
  bit [TimeW-1:0]  sect_start = '0;
  bit [TagW-1:0]   sect_tag   = '0;
  bit [DurW-1:0]   peak_dur   = '0;
  bit [TagW-1:0]   peak_tag   = '0;
  bit [DurW-1:0]   mean_dur   = '0;
  bit [CountW-1:0] n_samples  = '0;

  // Applies one event to the shadow state and returns the snapshot that the
  // monitor should show after it.
  function automatic monitor_snapshot_t apply_event(logic func, bit [TimeW-1:0] stamp,
                                                    bit [TagW-1:0] tag);
    monitor_snapshot_t snap;
    bit [DurW-1:0]     dur;
    bit [AccW-1:0]     acc;
    bit [AccW-1:0]     dvs;
    snap.status = STAT_OK;
    if (func == FUNC_START) begin
      // A second start while a section is open is dropped.
      if (sect_open) begin
        snap.status = STAT_START_OPEN;
      end else begin
        sect_start = stamp;
        sect_tag   = tag;
        sect_open  = 1'b1;
      end
    end else begin
      // A finish with nothing open is dropped; its tag is never used anyway.
      if (!sect_open) begin
        snap.status = STAT_FINISH_IDLE;
      end else begin
        dur = stamp - sect_start;
        // Only a strictly longer section takes over the maximum.
        if (dur > peak_dur) begin
          peak_dur = dur;
          peak_tag = sect_tag;
        end
        // The average freezes once the sample count has saturated.
        if (n_samples != {CountW{1'b1}}) begin
          acc       = AccW'(mean_dur) * AccW'(n_samples) + AccW'(dur);
          dvs       = AccW'(n_samples) + AccW'(1);
          mean_dur  = DurW'(acc / dvs);
          n_samples = n_samples + 1'b1;
        end
        sect_open = 1'b0;
      end
    end
    snap.open         = sect_open;
    snap.max_duration = peak_dur;
    snap.max_tag      = peak_tag;
    snap.avg_duration = mean_dur;
    snap.sample_count = n_samples;
    return snap;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_event(logic func, bit [TimeW-1:0] stamp, bit [TagW-1:0] tag,
                             bit drain = 1'b0);
    section_event_t item;
    item.func  = func;
    item.stamp = stamp;
    item.tag   = tag;
    item.drain = drain;
    event_backlog.push_back(item);
  endtask

  // Sender. It keeps valid high until the transfer happens, then works through
  // the backlog in bursts of random length separated by random gaps. The gaps
  // run up to about the length of a divide, so that they land on every phase
  // of the block's work. The transfer count is kept here, from the bus itself,
  // so that no other process is read at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    int unsigned burst_left;
    int unsigned gap_left;
    logic        taken;
    logic        next_valid;
    if (!rst_ni) begin
      evt.valid  <= 1'b0;
      evt.func   <= FUNC_START;
      evt.now    <= '0;
      evt.tag    <= '0;
      burst_left = 0;
      gap_left   = 0;
      in_flight  = 0;
    end else begin
      taken = evt.valid && evt.ready;
      if (taken) begin
        void'(event_backlog.pop_front());
        in_flight++;
      end
      if (res.valid && res.ready) begin
        in_flight--;
      end
      next_valid = 1'b0;
      if (evt.valid && !taken) begin
        next_valid = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (event_backlog.size() != 0 &&
                   !(event_backlog[0].drain && in_flight != 0)) begin
        next_valid = 1'b1;
        evt.func  <= event_backlog[0].func;
        evt.now   <= event_backlog[0].stamp;
        evt.tag   <= event_backlog[0].tag;
        if (burst_left <= 1) begin
          // Mostly short bursts with gaps, now and then a long run with none.
          if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(10, 40);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(0, 45);
          end
        end else begin
          burst_left--;
        end
      end
      evt.valid <= next_valid;
    end
  end

  // Receiver. At the end of each segment of random length it picks a habit: always
  // ready, ready at random, or mostly ready with long stalls.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned seg_left;
    int unsigned stall_left;
    int unsigned habit;
    logic        next_ready;
    if (!rst_ni) begin
      res.ready  <= 1'b0;
      seg_left   = 0;
      stall_left = 0;
      habit      = 0;
    end else begin
      if (seg_left == 0) begin
        habit    = $urandom_range(0, 2);
        seg_left = $urandom_range(50, 400);
      end else begin
        seg_left--;
      end
      next_ready = 1'b1;
      if (habit == 1) begin
        next_ready = 1'($urandom_range(0, 1));
      end else if (habit == 2) begin
        if (stall_left != 0) begin
          stall_left--;
          next_ready = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 40);
          next_ready = 1'b0;
        end
      end
      res.ready <= next_ready;
    end
  end

  // Monitor. Input and output transfers are observed in one process so that
  // an expectation is always queued before the result it belongs to is taken.
  always @(posedge clk_i) begin : result_check
    monitor_snapshot_t want;
    if (rst_ni) begin
      if (evt.valid && evt.ready) begin
        due_snapshots.push_back(apply_event(evt.func, evt.now, evt.tag));
      end
      if (res.valid && res.ready) begin
        if (due_snapshots.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(res.status), 0);
        end else begin
          want = due_snapshots.pop_front();
          if (res.status != want.status) begin
            report_mismatch("status", 32'(res.status), 32'(want.status));
          end
          if (res.open != want.open) begin
            report_mismatch("open", 32'(res.open), 32'(want.open));
          end
          if (res.max_duration != want.max_duration) begin
            report_mismatch("max_duration", res.max_duration, want.max_duration);
          end
          if (res.max_tag != want.max_tag) begin
            report_mismatch("max_tag", 32'(res.max_tag), 32'(want.max_tag));
          end
          if (res.avg_duration != want.avg_duration) begin
            report_mismatch("avg_duration", res.avg_duration, want.avg_duration);
          end
          if (res.sample_count != want.sample_count) begin
            report_mismatch("sample_count", res.sample_count, want.sample_count);
          end
        end
      end
    end
  end

  // Watchdog, far above the slowest correct run of the whole stimulus.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned     n_queued;
    bit [TimeW-1:0]  t0;
    bit [DurW-1:0]   dur;
    bit [DurW-1:0]   longest_made;
    int unsigned     pick;

    // The sender and the receiver drive their outputs while reset is held.
    rst_ni = 1'b0;

    // Directed part. A finish with nothing open, then a start ignored while
    // open, then a zero-length section with a tag on the finish to be ignored.
    queue_event(FUNC_FINISH, 32'hFFFF_FFFF, 16'hFFFF);
    queue_event(FUNC_START,  32'h0000_0000, 16'h0000);
    queue_event(FUNC_START,  32'hFFFF_FFFF, 16'hFFFF);
    queue_event(FUNC_FINISH, 32'h0000_0000, 16'hFFFF);
    // A section that wraps around the timestamp range sets a new maximum.
    queue_event(FUNC_START,  32'hFFFF_FFF0, 16'hA5A5);
    queue_event(FUNC_FINISH, 32'h0000_0010, 16'h0000);
    // The same duration again must leave the maximum and its tag alone.
    queue_event(FUNC_START,  32'h0000_0100, 16'h1234);
    queue_event(FUNC_FINISH, 32'h0000_0120, 16'h5A5A);
    // The longest possible section, a lone finish, then a second one of equal length.
    queue_event(FUNC_START,  32'h0000_0000, 16'hFFFF);
    queue_event(FUNC_FINISH, 32'hFFFF_FFFF, 16'h0000);
    queue_event(FUNC_FINISH, 32'h0000_0000, 16'h0000);
    queue_event(FUNC_START,  32'h0000_0005, 16'h0001);
    queue_event(FUNC_FINISH, 32'h0000_0004, 16'hFFFF);
    // Alternating bit patterns on every field, with a drain before them.
    queue_event(FUNC_START,  32'h5555_5555, 16'h5555, 1'b1);
    queue_event(FUNC_FINISH, 32'hAAAA_AAAA, 16'hAAAA);
    queue_event(FUNC_START,  32'hAAAA_AAAA, 16'hAAAA);
    queue_event(FUNC_START,  32'h5555_5555, 16'h5555);
    queue_event(FUNC_FINISH, 32'h5555_5555, 16'h5555);
    queue_event(FUNC_FINISH, 32'h1234_5678, 16'h8001);

    // Random part. Mostly well-formed start and finish pairs with random
    // timestamps and tags; the rest are lone starts and lone finishes.
    // Durations are mostly short so that the average moves, with some full
    // range ones and some that repeat the longest one made so far.
    n_queued     = 0;
    longest_made = '0;
    while (n_queued < RandomEvents) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        t0 = $urandom;
        case ($urandom_range(0, 9))
          0, 1:    dur = $urandom;
          2:       dur = longest_made;
          default: dur = $urandom_range(0, 2000);
        endcase
        if (dur > longest_made) begin
          longest_made = dur;
        end
        // Every so often the sender waits for all results before a pair.
        queue_event(FUNC_START, t0, 16'($urandom_range(0, 16'hFFFF)),
                    $urandom_range(0, 99) == 0);
        queue_event(FUNC_FINISH, t0 + dur, 16'($urandom_range(0, 16'hFFFF)));
        n_queued += 2;
      end else begin
        queue_event(pick == 8 ? FUNC_START : FUNC_FINISH, $urandom,
                    16'($urandom_range(0, 16'hFFFF)));
        n_queued++;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every event has been sent and every result has come back,
    // then give the block time to show any stray result.
    @(negedge clk_i);
    while (event_backlog.size() != 0 || evt.valid || in_flight != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatch_count == 0 && due_snapshots.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
